// ===== src/swc_pkg.sv =====
// shared types and constants for the sphere wall contact force core
// fixed Q16.16 widths, register indexes and the payload structs
// no dependencies
package swc_pkg;

  localparam int FracBits = 16;
  localparam int Lanes    = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int CoefW    = 31;
  localparam int DiffW    = 33;
  localparam int RadW     = 66;
  localparam int RootW    = 33;
  localparam int RemW     = 35;
  localparam int QuoW     = FracBits + 1;
  localparam int DivRemW  = RootW + 1;
  localparam int CompW    = 34;
  localparam int SqrtStages = RootW;
  localparam int DivStages  = QuoW;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_CENTER_Z      = 3'd2,
    REG_SPHERE_RADIUS = 3'd3,
    REG_STIFFNESS     = 3'd4,
    REG_DAMPING       = 3'd5,
    REG_INSIDE_MODE   = 3'd6
  } swc_reg_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] wall_vel_x;
    logic signed [31:0] wall_vel_y;
    logic signed [31:0] wall_vel_z;
    logic [CoefW-1:0]   particle_radius;
    logic [CoefW-1:0]   inv_mass;
  } swc_in_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic               in_contact;
  } swc_out_t;

  // carried alongside the root pipeline
  typedef struct packed {
    logic [Lanes-1:0][DiffW-1:0] d;
    logic [Lanes-1:0][DiffW-1:0] rv;
    logic [CoefW-1:0]            pr;
    logic [CoefW-1:0]            im;
  } swc_side_t;

  // carried alongside the divider pipeline
  typedef struct packed {
    logic [Lanes-1:0]            neg;
    logic [Lanes-1:0][DiffW-1:0] rv;
    logic [CoefW-1:0]            im;
    logic [CompW-1:0]            comp;
    logic                        contact;
  } swc_dside_t;

endpackage

// ===== src/swc_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// floor root of a 66 bit radicand, sideband travels with each item
// depends on swc_pkg
module swc_sqrt import swc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [RadW-1:0]  rad_i,
  input  swc_side_t        side_i,
  output logic             out_valid_o,
  output logic [RootW-1:0] root_o,
  output swc_side_t        side_o
);

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    swc_side_t        side;
  } sq_stage_t;

  function automatic sq_stage_t sq_step(sq_stage_t s, int pair);
    sq_stage_t       n;
    logic [RemW+1:0] acc;
    logic [RemW+1:0] trial;
    n      = s;
    acc    = {s.rem, s.rad[2*pair +: 2]};
    trial  = {2'b00, s.root, 2'b01};
    n.root = {s.root[RootW-2:0], 1'b0};
    n.rem  = acc[RemW-1:0];
    if (acc >= trial) begin
      n.root[0] = 1'b1;
      n.rem     = RemW'(acc - trial);
    end
    return n;
  endfunction

  logic [SqrtStages:0]   vld;
  logic [SqrtStages:1]   vld_q;
  sq_stage_t             stg   [0:SqrtStages];
  sq_stage_t             stg_q [1:SqrtStages];
  sq_stage_t             stg_d [0:SqrtStages-1];

  always_comb begin
    vld[0]       = in_valid_i;
    stg[0].rad   = rad_i;
    stg[0].rem   = '0;
    stg[0].root  = '0;
    stg[0].side  = side_i;
    for (int j = 1; j <= SqrtStages; j++) begin
      vld[j] = vld_q[j];
      stg[j] = stg_q[j];
    end
    // most significant bit pair first
    for (int j = 0; j < SqrtStages; j++) begin
      stg_d[j] = sq_step(stg[j], SqrtStages - 1 - j);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int j = 1; j <= SqrtStages; j++) begin
        vld_q[j] <= vld[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 1; j <= SqrtStages; j++) begin
      stg_q[j] <= stg_d[j-1];
    end
  end

  assign out_valid_o = vld[SqrtStages];
  assign root_o      = stg[SqrtStages].root;
  assign side_o      = stg[SqrtStages].side;

  logic [RadW:0] root_sq;
  logic [RadW:0] root1_sq;
  logic [RadW:0] rad_out;

  assign root_sq  = (RadW+1)'(root_o) * (RadW+1)'(root_o);
  assign root1_sq = ((RadW+1)'(root_o) + 1'b1) * ((RadW+1)'(root_o) + 1'b1);
  assign rad_out  = (RadW+1)'(stg[SqrtStages].rad);

  a_root_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> root_sq <= rad_out)
    else $error("root squared exceeds radicand");

  a_root_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> root1_sq > rad_out)
    else $error("root is not the floor root");

endmodule

// ===== src/swc_div.sv =====
// three lane pipelined restoring divider, one quotient bit per stage
// forms |d| * 2^16 / dist for each axis, sideband travels with each item
// depends on swc_pkg
module swc_div import swc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [Lanes-1:0][DiffW-1:0] dmag_i,
  input  logic [RootW-1:0]            dist_i,
  input  swc_dside_t                  side_i,
  output logic                        out_valid_o,
  output logic [Lanes-1:0][QuoW-1:0]  quo_o,
  output swc_dside_t                  side_o
);

  typedef struct packed {
    logic [Lanes-1:0][DivRemW-1:0] rem;
    logic [Lanes-1:0][QuoW-1:0]    quo;
    logic [RootW-1:0]              dvsr;
    swc_dside_t                    side;
  } dv_stage_t;

  function automatic dv_stage_t dv_step(dv_stage_t s);
    dv_stage_t          n;
    logic [DivRemW-1:0] r;
    logic               take;
    n = s;
    for (int l = 0; l < Lanes; l++) begin
      take     = s.rem[l] >= {1'b0, s.dvsr};
      r        = take ? s.rem[l] - {1'b0, s.dvsr} : s.rem[l];
      n.rem[l] = {r[DivRemW-2:0], 1'b0};
      n.quo[l] = {s.quo[l][QuoW-2:0], take};
    end
    return n;
  endfunction

  logic [DivStages:0] vld;
  logic [DivStages:1] vld_q;
  dv_stage_t          stg   [0:DivStages];
  dv_stage_t          stg_q [1:DivStages];
  dv_stage_t          stg_d [0:DivStages-1];

  always_comb begin
    vld[0]      = in_valid_i;
    stg[0].quo  = '0;
    stg[0].dvsr = dist_i;
    stg[0].side = side_i;
    // |d| never exceeds dist, so the top quotient bit is the integer part
    for (int l = 0; l < Lanes; l++) begin
      stg[0].rem[l] = {1'b0, dmag_i[l]};
    end
    for (int j = 1; j <= DivStages; j++) begin
      vld[j] = vld_q[j];
      stg[j] = stg_q[j];
    end
    for (int j = 0; j < DivStages; j++) begin
      stg_d[j] = dv_step(stg[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int j = 1; j <= DivStages; j++) begin
        vld_q[j] <= vld[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 1; j <= DivStages; j++) begin
      stg_q[j] <= stg_d[j-1];
    end
  end

  assign out_valid_o = vld[DivStages];
  assign quo_o       = stg[DivStages].quo;
  assign side_o      = stg[DivStages].side;

  a_num_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> (dmag_i[0] <= dist_i) && (dmag_i[1] <= dist_i) && (dmag_i[2] <= dist_i))
    else $error("offset larger than distance");

  a_unit_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && side_o.contact) |->
      (quo_o[0] <= (QuoW'(1) << FracBits)) && (quo_o[1] <= (QuoW'(1) << FracBits)) &&
      (quo_o[2] <= (QuoW'(1) << FracBits)))
    else $error("normal component above one");

endmodule

// ===== src/sphere_wall_contact_force_core.sv =====
// sphere wall contact force core: linear spring and dashpot against a sphere wall
// top level with config registers, root and divider pipelines and force datapath
// depends on swc_pkg, swc_sqrt and swc_div
//
// usage
//   items enter on item_i, taken at each rising edge with start_i high and busy_o low.
//   busy_o is never raised: the datapath is fully pipelined and takes one item every
//   cycle. each item yields exactly one result on result_o, marked by result_valid_o
//   for one cycle. results leave in input order.
//   the pipeline is made of the 33 stage root (one root bit per stage), the 17 stage
//   divider (one quotient bit per stage) and ten arithmetic stages around them.
//   config registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i with no
//   wait; write them only while no item is in flight. unknown indexes are ignored.
//   reset empties the pipeline and loads centre 0, radius 1.0, stiffness 100.0,
//   damping 0 and inside mode. the receiver takes every result; there is no stall.
module sphere_wall_contact_force_core import swc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  swc_in_t             item_i,
  output logic                result_valid_o,
  output swc_out_t            result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int VtMagW  = DiffW + QuoW - FracBits;
  localparam int VnW     = VtMagW + 3;
  localparam int SpringW = CoefW + CompW - FracBits;
  localparam int DmagW   = CoefW + VnW - FracBits;
  localparam int ForceW  = DmagW + 2;
  localparam int FmagW   = ForceW - 1;
  localparam int SplitW  = (FmagW + 1) / 2;
  localparam int PartW   = CoefW + SplitW;
  localparam int FullW   = CoefW + FmagW;
  localparam int MagW    = FullW - FracBits;
  localparam int CompExtW = CompW + 2;

  // ---------------- config registers ----------------
  logic [31:0]      center_x_q, center_y_q, center_z_q;
  logic [CoefW-1:0] sphere_radius_q, stiffness_q, damping_q;
  logic             inside_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q      <= '0;
      center_y_q      <= '0;
      center_z_q      <= '0;
      sphere_radius_q <= CoefW'(1) << FracBits;
      stiffness_q     <= CoefW'(100) << FracBits;
      damping_q       <= '0;
      inside_mode_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (swc_reg_e'(cfg_idx_i))
        REG_CENTER_X:      center_x_q      <= cfg_wdata_i;
        REG_CENTER_Y:      center_y_q      <= cfg_wdata_i;
        REG_CENTER_Z:      center_z_q      <= cfg_wdata_i;
        REG_SPHERE_RADIUS: sphere_radius_q <= cfg_wdata_i[CoefW-1:0];
        REG_STIFFNESS:     stiffness_q     <= cfg_wdata_i[CoefW-1:0];
        REG_DAMPING:       damping_q       <= cfg_wdata_i[CoefW-1:0];
        REG_INSIDE_MODE:   inside_mode_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // ---------------- valid chain ----------------
  logic a_v_q, b_v_q, c_v_q, e_v_q, f_v_q, g_v_q, h_v_q, i_v_q, j_v_q, k_v_q;
  logic s_v, dv_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
      i_v_q <= 1'b0;
      j_v_q <= 1'b0;
      k_v_q <= 1'b0;
    end else begin
      a_v_q <= start_i && !busy_o;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      e_v_q <= s_v;
      f_v_q <= dv_v;
      g_v_q <= f_v_q;
      h_v_q <= g_v_q;
      i_v_q <= h_v_q;
      j_v_q <= i_v_q;
      k_v_q <= j_v_q;
    end
  end

  // ---------------- stage a: offsets ----------------
  logic [Lanes-1:0][31:0] pos, vel, wvel, cen;
  swc_side_t              a_side_d, a_side_q;

  always_comb begin
    pos  = {item_i.pos_z, item_i.pos_y, item_i.pos_x};
    vel  = {item_i.vel_z, item_i.vel_y, item_i.vel_x};
    wvel = {item_i.wall_vel_z, item_i.wall_vel_y, item_i.wall_vel_x};
    cen  = {center_z_q, center_y_q, center_x_q};
    for (int l = 0; l < Lanes; l++) begin
      a_side_d.d[l]  = {pos[l][31], pos[l]} - {cen[l][31], cen[l]};
      a_side_d.rv[l] = {vel[l][31], vel[l]} - {wvel[l][31], wvel[l]};
    end
    a_side_d.pr = item_i.particle_radius;
    a_side_d.im = item_i.inv_mass;
  end

  // ---------------- stage b: squares ----------------
  logic [Lanes-1:0][DiffW-1:0] a_dmag;
  logic [Lanes-1:0][RadW-1:0]  b_sq_d, b_sq_q;
  swc_side_t                   b_side_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      a_dmag[l] = a_side_q.d[l][DiffW-1] ? -a_side_q.d[l] : a_side_q.d[l];
      b_sq_d[l] = RadW'(a_dmag[l]) * RadW'(a_dmag[l]);
    end
  end

  // ---------------- stage c: sum of squares ----------------
  logic [RadW-1:0] c_sum_q;
  swc_side_t       c_side_q;

  // ---------------- root ----------------
  logic [RootW-1:0] s_root;
  swc_side_t        s_side;

  swc_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (c_v_q),
    .rad_i       (c_sum_q),
    .side_i      (c_side_q),
    .out_valid_o (s_v),
    .root_o      (s_root),
    .side_o      (s_side)
  );

  // ---------------- stage e: compression and normal signs ----------------
  logic [CompExtW-1:0]         comp_ext;
  logic [Lanes-1:0][DiffW-1:0] e_dmag_d, e_dmag_q;
  logic [RootW-1:0]            e_dist_q;
  swc_dside_t                  e_side_d, e_side_q;

  always_comb begin
    if (inside_mode_q) begin
      comp_ext = CompExtW'(s_root) + CompExtW'(s_side.pr) - CompExtW'(sphere_radius_q);
    end else begin
      comp_ext = CompExtW'(sphere_radius_q) - CompExtW'(s_root) + CompExtW'(s_side.pr);
    end
    for (int l = 0; l < Lanes; l++) begin
      e_dmag_d[l]     = s_side.d[l][DiffW-1] ? -s_side.d[l] : s_side.d[l];
      e_side_d.neg[l] = s_side.d[l][DiffW-1] ^ inside_mode_q;
    end
    e_side_d.rv      = s_side.rv;
    e_side_d.im      = s_side.im;
    e_side_d.comp    = comp_ext[CompW-1:0];
    // zero distance gives no force
    e_side_d.contact = (s_root != '0) && !comp_ext[CompExtW-1] && (comp_ext != '0);
  end

  // ---------------- normal division ----------------
  logic [Lanes-1:0][QuoW-1:0] dv_quo;
  swc_dside_t                 dv_side;

  swc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (e_v_q),
    .dmag_i      (e_dmag_q),
    .dist_i      (e_dist_q),
    .side_i      (e_side_q),
    .out_valid_o (dv_v),
    .quo_o       (dv_quo),
    .side_o      (dv_side)
  );

  // ---------------- stage f: first products ----------------
  logic [Lanes-1:0][DiffW-1:0]      rvm;
  logic [Lanes-1:0][DiffW+QuoW-1:0] vprod;
  logic [Lanes-1:0][CoefW+QuoW-1:0] mprod;
  logic [CoefW+CompW-1:0]           sprod;
  logic [Lanes-1:0][VnW-1:0]        f_vt_d, f_vt_q;
  logic [Lanes-1:0][CoefW-1:0]      f_mmag_d, f_mmag_q;
  logic [Lanes-1:0]                 f_mneg_q;
  logic [SpringW-1:0]               f_spring_q;
  logic                             f_contact_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      rvm[l]      = dv_side.rv[l][DiffW-1] ? -dv_side.rv[l] : dv_side.rv[l];
      vprod[l]    = (DiffW+QuoW)'(rvm[l]) * (DiffW+QuoW)'(dv_quo[l]);
      f_vt_d[l]   = (dv_side.rv[l][DiffW-1] ^ dv_side.neg[l]) ?
                    -VnW'(vprod[l][DiffW+QuoW-1:FracBits]) :
                    VnW'(vprod[l][DiffW+QuoW-1:FracBits]);
      mprod[l]    = (CoefW+QuoW)'(dv_side.im) * (CoefW+QuoW)'(dv_quo[l]);
      f_mmag_d[l] = mprod[l][CoefW+FracBits-1:FracBits];
    end
    sprod = (CoefW+CompW)'(stiffness_q) * (CoefW+CompW)'(dv_side.comp);
  end

  // ---------------- stage g: normal relative velocity ----------------
  logic [VnW-1:0]              g_vn_q;
  logic [SpringW-1:0]          g_spring_q;
  logic [Lanes-1:0][CoefW-1:0] g_mmag_q;
  logic [Lanes-1:0]            g_mneg_q;
  logic                        g_contact_q;

  // ---------------- stage h: damping term ----------------
  logic [VnW-1:0]          vnm;
  logic [CoefW+VnW-1:0]    dprod;
  logic [DmagW-1:0]        h_dmag_q;
  logic                    h_dneg_q;
  logic [SpringW-1:0]      h_spring_q;
  logic [Lanes-1:0][CoefW-1:0] h_mmag_q;
  logic [Lanes-1:0]        h_mneg_q;
  logic                    h_contact_q;

  always_comb begin
    vnm   = g_vn_q[VnW-1] ? -g_vn_q : g_vn_q;
    dprod = (CoefW+VnW)'(damping_q) * (CoefW+VnW)'(vnm);
  end

  // ---------------- stage i: force ----------------
  logic [ForceW-1:0]           force_s;
  logic [ForceW-1:0]           force_m;
  logic [FmagW-1:0]            i_fmag_q;
  logic                        i_fneg_q;
  logic [Lanes-1:0][CoefW-1:0] i_mmag_q;
  logic [Lanes-1:0]            i_mneg_q;
  logic                        i_contact_q;

  always_comb begin
    if (h_dneg_q) begin
      force_s = ForceW'(h_spring_q) + ForceW'(h_dmag_q);
    end else begin
      force_s = ForceW'(h_spring_q) - ForceW'(h_dmag_q);
    end
    force_m = force_s[ForceW-1] ? -force_s : force_s;
  end

  // ---------------- stage j: split final products ----------------
  logic [Lanes-1:0][PartW-1:0] j_lo_d, j_lo_q, j_hi_d, j_hi_q;
  logic [Lanes-1:0]            j_neg_q;
  logic                        j_contact_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      j_lo_d[l] = PartW'(i_mmag_q[l]) * PartW'(i_fmag_q[SplitW-1:0]);
      j_hi_d[l] = PartW'(i_mmag_q[l]) * PartW'(i_fmag_q[FmagW-1:SplitW]);
    end
  end

  // ---------------- stage k: combine and saturate ----------------
  logic [Lanes-1:0][FullW-1:0] full;
  logic [Lanes-1:0][MagW-1:0]  mag;
  logic [Lanes-1:0][31:0]      acc_d;
  swc_out_t                    k_out_d, k_out_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      full[l] = (FullW'(j_hi_q[l]) << SplitW) + FullW'(j_lo_q[l]);
      mag[l]  = full[l][FullW-1:FracBits];
      if (!j_contact_q) begin
        acc_d[l] = '0;
      end else if (!j_neg_q[l]) begin
        acc_d[l] = (mag[l][MagW-1:31] != '0) ? 32'h7FFF_FFFF : {1'b0, mag[l][30:0]};
      end else begin
        acc_d[l] = (mag[l][MagW-1:31] != '0) ? 32'h8000_0000 : -{1'b0, mag[l][30:0]};
      end
    end
    k_out_d.accel_x    = acc_d[0];
    k_out_d.accel_y    = acc_d[1];
    k_out_d.accel_z    = acc_d[2];
    k_out_d.in_contact = j_contact_q;
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    a_side_q    <= a_side_d;
    b_sq_q      <= b_sq_d;
    b_side_q    <= a_side_q;
    c_sum_q     <= b_sq_q[0] + b_sq_q[1] + b_sq_q[2];
    c_side_q    <= b_side_q;
    e_dmag_q    <= e_dmag_d;
    e_dist_q    <= s_root;
    e_side_q    <= e_side_d;
    f_vt_q      <= f_vt_d;
    f_mmag_q    <= f_mmag_d;
    f_mneg_q    <= dv_side.neg;
    f_spring_q  <= sprod[CoefW+CompW-1:FracBits];
    f_contact_q <= dv_side.contact;
    g_vn_q      <= f_vt_q[0] + f_vt_q[1] + f_vt_q[2];
    g_spring_q  <= f_spring_q;
    g_mmag_q    <= f_mmag_q;
    g_mneg_q    <= f_mneg_q;
    g_contact_q <= f_contact_q;
    h_dmag_q    <= dprod[CoefW+VnW-1:FracBits];
    h_dneg_q    <= g_vn_q[VnW-1];
    h_spring_q  <= g_spring_q;
    h_mmag_q    <= g_mmag_q;
    h_mneg_q    <= g_mneg_q;
    h_contact_q <= g_contact_q;
    i_fmag_q    <= force_m[FmagW-1:0];
    i_fneg_q    <= force_s[ForceW-1];
    i_mmag_q    <= h_mmag_q;
    i_mneg_q    <= h_mneg_q;
    i_contact_q <= h_contact_q;
    j_lo_q      <= j_lo_d;
    j_hi_q      <= j_hi_d;
    j_neg_q     <= i_mneg_q ^ {Lanes{i_fneg_q}};
    j_contact_q <= i_contact_q;
    k_out_q     <= k_out_d;
  end

  assign result_valid_o = k_v_q;
  assign result_o       = k_out_q;

  a_no_contact_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.in_contact) |->
      (result_o.accel_x == '0) && (result_o.accel_y == '0) && (result_o.accel_z == '0))
    else $error("force without contact");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$isunknown(result_o))
    else $error("unknown bits in result");

endmodule
